@@ hdl/ctt_pkg.sv @@
// Shared types and constants for the config text tokenizer.
`default_nettype none
package ctt_pkg;
   localparam int OFFSET_BITS = 24;
   localparam int LINE_BITS   = 20;
   localparam int COLUMN_BITS = 16;

   localparam logic [4:0] KIND_NULL     = 5'd9;
   localparam logic [4:0] KIND_TRUE     = 5'd10;
   localparam logic [4:0] KIND_FALSE    = 5'd11;
   localparam logic [4:0] KIND_IDENT    = 5'd12;
   localparam logic [4:0] KIND_INT      = 5'd13;
   localparam logic [4:0] KIND_DEC      = 5'd14;
   localparam logic [4:0] KIND_STRING   = 5'd15;
   localparam logic [4:0] KIND_EOF      = 5'd16;
   localparam logic [4:0] KIND_BAD      = 5'd17;
   localparam logic [4:0] KIND_UNCLOSED = 5'd18;

   localparam logic [4:0] MAX_FRACTION = 5'd18;

   // One result token as it travels from the scanner to the output queue.
   typedef struct packed {
      logic [4:0]             kind;
      logic [63:0]            value;
      logic [4:0]             frac;
      logic                   ovf;
      logic [LINE_BITS-1:0]   line;
      logic [COLUMN_BITS-1:0] col;
      logic [OFFSET_BITS-1:0] off;
      logic [15:0]            len;
      logic                   last;
   } token_type;

   // Punctuation code of a byte; valid flag in the top bit.
   function automatic logic [5:0] punct_code(input logic [7:0] c);
      logic [5:0] r;
      r = 6'd0;
      case (c)
         8'h3D: r = {1'b1, 5'd0};
         8'h3B: r = {1'b1, 5'd1};
         8'h2C: r = {1'b1, 5'd2};
         8'h7B: r = {1'b1, 5'd3};
         8'h7D: r = {1'b1, 5'd4};
         8'h28: r = {1'b1, 5'd5};
         8'h29: r = {1'b1, 5'd6};
         8'h5B: r = {1'b1, 5'd7};
         8'h5D: r = {1'b1, 5'd8};
         default: r = 6'd0;
      endcase
      return r;
   endfunction
endpackage
`default_nettype wire

@@ hdl/config_text_tokenizer.sv @@
// Top level of the config text tokenizer.
// Takes one text byte per cycle while at most four tokens wait in the eight-entry
// token queue, and stalls the input otherwise; it emits one token per output
// transaction. The scanner decides each byte combinationally, so bytes sustain one
// per cycle while results are taken. Each byte causes at most two tokens; a token is
// queued as the byte that ends it is accepted and offered once earlier ones are taken.
`default_nettype none
module config_text_tokenizer import ctt_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_cmd,
   input  wire logic [7:0]  req_text_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [4:0]       rsp_token_kind,
   output logic signed [63:0] rsp_number_value,
   output logic [4:0]       rsp_fraction_digits,
   output logic             rsp_number_overflow,
   output logic [LINE_BITS-1:0]   rsp_start_line,
   output logic [COLUMN_BITS-1:0] rsp_start_column,
   output logic [OFFSET_BITS-1:0] rsp_start_offset,
   output logic [15:0]      rsp_token_length,
   output logic             rsp_last_of_run
);
   token_type t0, t1, ot;
   logic [1:0] cnt;
   logic room, take;

   assign req_stall = !room;
   assign take = req_valid && room;

   ctt_scan u_scan (.clock, .reset, .byte_valid(take),
      .byte_end(req_cmd || (req_text_byte == 8'd0)), .byte_data(req_text_byte),
      .tok0(t0), .tok1(t1), .tok_count(cnt));

   ctt_queue u_queue (.clock, .reset, .tok0(t0), .tok1(t1), .tok_count(cnt),
      .has_room(room), .out_valid(rsp_valid), .out_tok(ot), .out_stall(rsp_stall));

   assign rsp_token_kind      = ot.kind;
   assign rsp_number_value    = ot.value;
   assign rsp_fraction_digits = ot.frac;
   assign rsp_number_overflow = ot.ovf;
   assign rsp_start_line      = ot.line;
   assign rsp_start_column    = ot.col;
   assign rsp_start_offset    = ot.off;
   assign rsp_token_length    = ot.len;
   assign rsp_last_of_run     = ot.last;
endmodule
`default_nettype wire

@@ hdl/ctt_scan.sv @@
// Front part: scans one byte per cycle and produces up to two tokens.
`default_nettype none
module ctt_scan import ctt_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      byte_valid,
   input  wire logic      byte_end,
   input  wire logic [7:0] byte_data,
   output token_type      tok0,
   output token_type      tok1,
   output logic [1:0]     tok_count
);
   typedef enum logic [3:0] {
      M_IDLE, M_SLASH, M_COMMENT, M_IDENT, M_NUMBER, M_FRACTION,
      M_STRING, M_ESCAPE, M_DEAD
   } mode_type;

   localparam logic [OFFSET_BITS-1:0] OFF_TOP = '1;
   localparam logic [LINE_BITS-1:0]   LINE_TOP = '1;
   localparam logic [COLUMN_BITS-1:0] COL_TOP = '1;

   mode_type mode_ff, mode_in;
   logic [LINE_BITS-1:0]   line_ff, line_in, sline_ff, sline_in;
   logic [COLUMN_BITS-1:0] col_ff, col_in, scol_ff, scol_in;
   logic [OFFSET_BITS-1:0] off_ff, off_in, soff_ff, soff_in;
   logic [15:0] len_ff, len_in;
   logic [63:0] mant_ff, mant_in;
   logic neg_ff, neg_in, ovf_ff, ovf_in;
   logic [4:0] frac_ff, frac_in;
   logic [39:0] kw_ff, kw_in;

   logic c_nl, c_sp, c_dig, c_head, c_body;
   logic [5:0] pc;
   logic [3:0] dig;
   logic [63:0] limit, times10, sum;
   logic [64:0] wide;
   logic fits;
   token_type t0, t1, pend, startok, eoftok;
   logic [1:0] n;
   logic go_idle;
   logic [15:0] len_inc;

   // Byte classes.
   always_comb begin
      c_nl   = (byte_data == 8'd10) || (byte_data == 8'd13);
      c_sp   = c_nl || (byte_data == 8'd32) || (byte_data == 8'd9);
      c_dig  = (byte_data >= 8'd48) && (byte_data <= 8'd57);
      c_head = ((byte_data >= 8'd97) && (byte_data <= 8'd122)) ||
               ((byte_data >= 8'd65) && (byte_data <= 8'd90)) || (byte_data == 8'd95);
      c_body = c_head || c_dig;
      pc     = punct_code(byte_data);
      dig    = byte_data[3:0] - 4'd0;
   end

   // Digit accumulate with saturation: fits when acc*10+d stays within limit.
   always_comb begin
      limit   = neg_ff ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      times10 = (mant_ff << 3) + (mant_ff << 1);
      wide    = {1'b0, times10} + {61'd0, dig};
      sum     = wide[63:0];
      fits    = (mant_ff <= 64'h0CCC_CCCC_CCCC_CCCC) && !wide[64] && (sum <= limit);
   end

   // Token templates.
   always_comb begin
      startok = '0;
      startok.line = sline_ff;
      startok.col  = scol_ff;
      startok.off  = soff_ff;
      startok.len  = len_ff;
      eoftok = '0;
      eoftok.kind = KIND_EOF;
      eoftok.line = line_ff;
      eoftok.col  = col_ff;
      eoftok.off  = off_ff;
      pend = startok;
      if (mode_ff == M_IDENT) begin
         pend.kind = KIND_IDENT;
         if (len_ff == 16'd4 && kw_ff == 40'h6E756C6C) pend.kind = KIND_NULL;
         else if (len_ff == 16'd4 && kw_ff == 40'h74727565) pend.kind = KIND_TRUE;
         else if (len_ff == 16'd5 && kw_ff == 40'h66616C7365) pend.kind = KIND_FALSE;
      end else begin
         pend.value = neg_ff ? (64'd0 - mant_ff) : mant_ff;
         pend.ovf   = ovf_ff;
         if (mode_ff == M_FRACTION) begin
            pend.kind = KIND_DEC;
            pend.frac = frac_ff;
         end else begin
            pend.kind = KIND_INT;
         end
      end
      len_inc = (len_ff != 16'hFFFF) ? len_ff + 16'd1 : len_ff;
   end

   // Scanner next state.
   always_comb begin
      mode_in = mode_ff;
      sline_in = sline_ff; scol_in = scol_ff; soff_in = soff_ff;
      len_in = len_ff; mant_in = mant_ff; neg_in = neg_ff; ovf_in = ovf_ff;
      frac_in = frac_ff; kw_in = kw_ff;
      t0 = '0; t1 = '0; n = 2'd0; go_idle = 1'b0;
      line_in = line_ff; col_in = col_ff; off_in = off_ff;
      if (byte_valid) begin
         unique case (mode_ff)
            M_DEAD: ;
            M_STRING, M_ESCAPE: begin
               if (byte_end || (mode_ff == M_STRING && c_nl)) begin
                  t0 = startok; t0.kind = KIND_UNCLOSED; n = 2'd1; mode_in = M_DEAD;
               end else begin
                  len_in = len_inc;
                  if (mode_ff == M_ESCAPE) mode_in = M_STRING;
                  else if (byte_data == 8'h22) begin
                     t0 = startok; t0.kind = KIND_STRING; t0.len = len_inc;
                     n = 2'd1; mode_in = M_IDLE;
                  end else if (byte_data == 8'h5C) mode_in = M_ESCAPE;
               end
            end
            M_COMMENT: begin
               if (byte_end) begin
                  t0 = eoftok; n = 2'd1; mode_in = M_DEAD;
               end else if (c_nl) mode_in = M_IDLE;
            end
            M_SLASH: begin
               if (byte_end || byte_data != 8'h2F) begin
                  t0 = startok; t0.kind = KIND_BAD; n = 2'd1; mode_in = M_DEAD;
               end else mode_in = M_COMMENT;
            end
            M_IDENT: begin
               if (!byte_end && c_body) begin
                  len_in = len_inc; kw_in = {kw_ff[31:0], byte_data};
               end else begin
                  t0 = pend; n = 2'd1; go_idle = 1'b1;
               end
            end
            M_NUMBER: begin
               if (!byte_end && c_dig) begin
                  len_in = len_inc;
                  if (fits) mant_in = sum;
                  else begin mant_in = limit; ovf_in = 1'b1; end
               end else if (!byte_end && byte_data == 8'h2E) begin
                  len_in = len_inc; mode_in = M_FRACTION;
               end else begin
                  t0 = pend; n = 2'd1; go_idle = 1'b1;
               end
            end
            M_FRACTION: begin
               if (!byte_end && c_dig) begin
                  len_in = len_inc;
                  if (frac_ff >= MAX_FRACTION || !fits) ovf_in = 1'b1;
                  else begin mant_in = sum; frac_in = frac_ff + 5'd1; end
               end else begin
                  t0 = pend; n = 2'd1; go_idle = 1'b1;
               end
            end
            default: go_idle = 1'b1;
         endcase

         // Idle handling: this byte may start a new token.
         if (go_idle) begin
            mode_in = M_IDLE;
            if (byte_end) begin
               if (n == 2'd0) t0 = eoftok; else t1 = eoftok;
               n = n + 2'd1; mode_in = M_DEAD;
            end else if (!c_sp) begin
               sline_in = line_ff; scol_in = col_ff; soff_in = off_ff; len_in = 16'd1;
               t1 = '0;
               t1.line = line_ff; t1.col = col_ff; t1.off = off_ff; t1.len = 16'd1;
               if (pc[5]) begin
                  t1.kind = pc[4:0]; n = n + 2'd1;
               end else if (byte_data == 8'h2F) mode_in = M_SLASH;
               else if (byte_data == 8'h22) mode_in = M_STRING;
               else if (c_dig || byte_data == 8'h2E || byte_data == 8'h2B ||
                        byte_data == 8'h2D) begin
                  mant_in = c_dig ? {60'd0, dig} : 64'd0;
                  neg_in = (byte_data == 8'h2D);
                  frac_in = 5'd0; ovf_in = 1'b0;
                  mode_in = (byte_data == 8'h2E) ? M_FRACTION : M_NUMBER;
               end else if (c_head) begin
                  kw_in = {32'd0, byte_data}; mode_in = M_IDENT;
               end else begin
                  t1.kind = KIND_BAD; n = n + 2'd1; mode_in = M_DEAD;
               end
               if (mode_ff != M_IDENT && mode_ff != M_NUMBER && mode_ff != M_FRACTION)
                  t0 = t1;
            end
         end

         // Position counters.
         if (!byte_end && mode_ff != M_DEAD) begin
            if (off_ff != OFF_TOP) off_in = off_ff + OFFSET_BITS'(1);
            if (c_nl) begin
               if (line_ff != LINE_TOP) line_in = line_ff + LINE_BITS'(1);
               col_in = {{(COLUMN_BITS-1){1'b0}}, 1'b1};
            end else if (col_ff != COL_TOP) col_in = col_ff + COLUMN_BITS'(1);
         end
      end
      if (n == 2'd1) t0.last = 1'b1;
      if (n == 2'd2) t1.last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_IDLE;
         line_ff <= {{(LINE_BITS-1){1'b0}}, 1'b1};
         col_ff  <= {{(COLUMN_BITS-1){1'b0}}, 1'b1};
         off_ff  <= '0;
         sline_ff <= {{(LINE_BITS-1){1'b0}}, 1'b1};
         scol_ff  <= {{(COLUMN_BITS-1){1'b0}}, 1'b1};
         soff_ff <= '0; len_ff <= '0; mant_ff <= '0; neg_ff <= 1'b0;
         ovf_ff <= 1'b0; frac_ff <= '0; kw_ff <= '0;
      end else begin
         mode_ff <= mode_in; line_ff <= line_in; col_ff <= col_in; off_ff <= off_in;
         sline_ff <= sline_in; scol_ff <= scol_in; soff_ff <= soff_in;
         len_ff <= len_in; mant_ff <= mant_in; neg_ff <= neg_in; ovf_ff <= ovf_in;
         frac_ff <= frac_in; kw_ff <= kw_in;
      end
   end

   assign tok0 = t0;
   assign tok1 = t1;
   assign tok_count = n;

   // Once dead, the scanner stays in that mode until reset.
   a_dead: assert property (@(posedge clock) disable iff (reset)
      mode_ff == M_DEAD |=> mode_ff == M_DEAD) else $error("left dead mode");
   a_dead_quiet: assert property (@(posedge clock) disable iff (reset)
      mode_ff == M_DEAD |-> tok_count == 2'd0) else $error("token after dead");
   a_two: assert property (@(posedge clock) disable iff (reset)
      tok_count == 2'd2 |-> tok1.last && !tok0.last) else $error("bad last flag");
endmodule
`default_nettype wire

@@ hdl/ctt_queue.sv @@
// Back part: token queue that drains one token per transaction.
`default_nettype none
module ctt_queue import ctt_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  token_type      tok0,
   input  token_type      tok1,
   input  wire logic [1:0] tok_count,
   output logic           has_room,
   output logic           out_valid,
   output token_type      out_tok,
   input  wire logic      out_stall
);
   token_type mem_ff [8];
   logic [2:0] wr_ff, rd_ff;
   logic [3:0] cnt_ff, cnt_in;
   logic pop;

   assign pop = out_valid && !out_stall;
   assign out_valid = cnt_ff != 4'd0;
   assign out_tok = mem_ff[rd_ff];
   // Room for two more tokens after this cycle's possible pushes.
   assign has_room = cnt_ff <= 4'd4;
   assign cnt_in = cnt_ff + {2'd0, tok_count} - {3'd0, pop};

   // Write up to two tokens, read one.
   always_ff @(posedge clock) begin
      if (tok_count != 2'd0) mem_ff[wr_ff] <= tok0;
      if (tok_count == 2'd2) mem_ff[wr_ff + 3'd1] <= tok1;
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; cnt_ff <= '0;
      end else begin
         wr_ff <= wr_ff + {1'b0, tok_count};
         rd_ff <= rd_ff + {2'd0, pop};
         cnt_ff <= cnt_in;
      end
   end

   a_ovf: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 4'd8) else $error("queue overflow");
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      (tok_count == 2'd0 && !pop) |=> $stable(cnt_ff)) else $error("count drift");
   a_room: assert property (@(posedge clock) disable iff (reset)
      !has_room |-> cnt_ff > 4'd4) else $error("room flag wrong");
endmodule
`default_nettype wire
